// ===== rtl/gfpat_pkg.sv =====
// Shared types, constants and field decoding for the gyro frame parser.
`timescale 1ns / 1ps

package gfpat_pkg;

  localparam int unsigned FRAME_LEN_DEF = 15;
  localparam logic [7:0]  SYNC_RESET    = 8'hAA;

  // Frame positions of the little-endian fields (low byte position)
  localparam int unsigned POS_ANGLE   = 3;
  localparam int unsigned POS_RATE    = 5;
  localparam int unsigned POS_ACCEL_X = 7;
  localparam int unsigned POS_ACCEL_Y = 9;
  localparam int unsigned POS_ACCEL_Z = 11;
  localparam int unsigned POS_FIRST   = POS_ANGLE;
  localparam int unsigned POS_LAST    = POS_ACCEL_Z + 1;

  localparam int unsigned FIELD_W = 17;
  localparam int unsigned TURNS_W = 16;
  localparam int unsigned DIFF_W  = FIELD_W + 1;

  localparam logic signed [DIFF_W-1:0] HALF_TURN = 18'sd18000;
  localparam logic signed [DIFF_W-1:0] FULL_TURN = 18'sd36000;

  typedef logic signed [FIELD_W-1:0] field_t;

  // One decoded frame handed from the parser to the tracker
  typedef struct packed {
    field_t angle;
    field_t rate;
    field_t accel_x;
    field_t accel_y;
    field_t accel_z;
    logic   capture;
  } frame_t;

  // Negate a 16-bit little-endian field read as a signed value
  function automatic field_t decode_field(input logic [7:0] lo, input logic [7:0] hi);
    logic [FIELD_W-1:0] v;
    v = {1'b0, hi, lo};
    if (!v[15]) begin
      decode_field = field_t'(17'd0 - v);
    end else begin
      decode_field = field_t'(17'h10000 - v);
    end
  endfunction

endpackage

// ===== rtl/gfpat_parser.sv =====
// Sync hunt, byte collection and field decode into the frame register.
`timescale 1ns / 1ps

module gfpat_parser import gfpat_pkg::*; #(
  parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       arm_zero,
  output logic       f_valid,
  input  logic       f_ready,
  output frame_t     frame
);

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);

  logic [7:0]       sync_byte;
  logic [IDX_W-1:0] byte_index;
  logic             in_frame;
  logic             zero_armed;
  logic [7:0]       frame_bytes [POS_FIRST:POS_LAST];
  logic [7:0]       view        [POS_FIRST:POS_LAST];

  logic accept;
  logic armed_now;
  logic last_byte;
  logic complete;

  assign in_ready  = !f_valid || f_ready;
  assign accept    = in_valid && in_ready;
  assign armed_now = zero_armed || arm_zero;
  assign last_byte = byte_index == IDX_W'(FRAME_LEN - 1);
  assign complete  = accept && in_frame && last_byte;

  // Bypass the byte arriving now into the decode view
  always_comb begin
    for (int k = POS_FIRST; k <= POS_LAST; k++) begin
      view[k] = (byte_index == IDX_W'(k)) ? rx_byte : frame_bytes[k];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame) begin
      for (int k = POS_FIRST; k <= POS_LAST; k++) begin
        if (byte_index == IDX_W'(k)) begin
          frame_bytes[k] <= rx_byte;
        end
      end
    end
    if (complete) begin
      frame.angle   <= decode_field(view[POS_ANGLE],   view[POS_ANGLE + 1]);
      frame.rate    <= decode_field(view[POS_RATE],    view[POS_RATE + 1]);
      frame.accel_x <= decode_field(view[POS_ACCEL_X], view[POS_ACCEL_X + 1]);
      frame.accel_y <= decode_field(view[POS_ACCEL_Y], view[POS_ACCEL_Y + 1]);
      frame.accel_z <= decode_field(view[POS_ACCEL_Z], view[POS_ACCEL_Z + 1]);
      frame.capture <= armed_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= SYNC_RESET;
      byte_index <= '0;
      in_frame   <= 1'b0;
      zero_armed <= 1'b1;
      f_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sync_byte <= cfg_wr_data;
      end
      if (f_valid && f_ready) begin
        f_valid <= 1'b0;
      end
      if (accept) begin
        zero_armed <= armed_now;
        if (!in_frame) begin
          if (rx_byte == sync_byte) begin
            in_frame   <= 1'b1;
            byte_index <= IDX_W'(1);
          end
        end else if (last_byte) begin
          in_frame   <= 1'b0;
          byte_index <= '0;
          zero_armed <= 1'b0;
          f_valid    <= 1'b1;
        end else begin
          byte_index <= byte_index + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/gfpat_tracker.sv =====
// Zero capture, relative angle wrap, turn counting and the result register.
`timescale 1ns / 1ps

module gfpat_tracker import gfpat_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       f_valid,
  output logic                       f_ready,
  input  frame_t                     frame,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [FIELD_W-1:0]  rel_angle,
  output logic signed [FIELD_W-1:0]  raw_angle,
  output logic signed [FIELD_W-1:0]  rate,
  output logic signed [FIELD_W-1:0]  accel_x,
  output logic signed [FIELD_W-1:0]  accel_y,
  output logic signed [FIELD_W-1:0]  accel_z,
  output logic signed [TURNS_W-1:0]  turn_count
);

  field_t                    zero_angle;
  field_t                    prev_rel_angle;
  logic [TURNS_W-1:0]        turns;

  field_t                    zero_eff;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  wrapped;
  field_t                    rel_next;
  logic [TURNS_W-1:0]        turns_next;
  logic                      take;

  assign f_ready = !out_valid || out_ready;
  assign take    = f_valid && f_ready;

  always_comb begin
    zero_eff = frame.capture ? frame.angle : zero_angle;
    diff     = DIFF_W'(frame.angle) - DIFF_W'(zero_eff);
    if (diff > HALF_TURN) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      wrapped = diff + FULL_TURN;
    end else begin
      wrapped = diff;
    end
    rel_next   = field_t'(wrapped);
    turns_next = turns;
    // Count a turn only when the rate agrees with the sign crossing
    if (rel_next > 0 && prev_rel_angle < 0 && frame.rate < 0) begin
      turns_next = turns - 1'b1;
    end
    if (rel_next < 0 && prev_rel_angle > 0 && frame.rate > 0) begin
      turns_next = turns + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rel_angle  <= rel_next;
      raw_angle  <= frame.angle;
      rate       <= frame.rate;
      accel_x    <= frame.accel_x;
      accel_y    <= frame.accel_y;
      accel_z    <= frame.accel_z;
      turn_count <= turns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      zero_angle     <= '0;
      prev_rel_angle <= '0;
      turns          <= '0;
    end else begin
      if (take) begin
        out_valid      <= 1'b1;
        zero_angle     <= zero_eff;
        prev_rel_angle <= rel_next;
        turns          <= turns_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/gyro_frame_parser_angle_tracker_unit.sv =====
// Top level of the gyro frame parser and angle tracker.
`timescale 1ns / 1ps

// Takes one serial byte per input beat, one beat per clock when both sides
// keep up. While idle, hunt for a byte equal to the sync register; that byte
// is frame position 0, and the next FRAME_LEN-1 beats complete the frame.
// On the last byte, decode the little-endian angle, rate and three
// acceleration words, negate each as a signed value and hold them in the
// frame register; from there the tracker forms the angle relative to the
// captured zero (centidegrees, one wrap by 36000, which lands within +-18000
// unless the difference exceeds 54000 in size), updates the turn counter on
// rate-agreed sign crossings and loads the result register.
// A beat with arm_zero high makes the next completed frame (including one that
// completes on that same beat) capture its own angle as zero; the first frame
// after reset captures likewise. Bytes that do not complete a frame give no
// result. A decoded frame waits in the frame register until the result
// register takes it; the two registers each decouple their sides, so input
// beats keep flowing while one result waits on out_ready; only once a
// second decoded frame also sits in the frame register does in_ready drop.
// Write the sync register only while no frame is in flight or waiting at the
// output.

module gyro_frame_parser_angle_tracker_unit import gfpat_pkg::*; #(
  parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [7:0]                cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                rx_byte,
  input  logic                      arm_zero,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FIELD_W-1:0] rel_angle,
  output logic signed [FIELD_W-1:0] raw_angle,
  output logic signed [FIELD_W-1:0] rate,
  output logic signed [FIELD_W-1:0] accel_x,
  output logic signed [FIELD_W-1:0] accel_y,
  output logic signed [FIELD_W-1:0] accel_z,
  output logic signed [TURNS_W-1:0] turn_count
);

  // Decoded frame travelling between parser and tracker
  logic   f_valid;
  logic   f_ready;
  frame_t frame;

  gfpat_parser #(
    .FRAME_LEN (FRAME_LEN)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .arm_zero    (arm_zero),
    .f_valid     (f_valid),
    .f_ready     (f_ready),
    .frame       (frame)
  );

  gfpat_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .f_valid    (f_valid),
    .f_ready    (f_ready),
    .frame      (frame),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rel_angle  (rel_angle),
    .raw_angle  (raw_angle),
    .rate       (rate),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .turn_count (turn_count)
  );

endmodule

// ===== rtl/gfpat_checker.sv =====
// Port-level checks for the gyro frame parser, bound to the top level.
`timescale 1ns / 1ps

module gfpat_checker import gfpat_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [FIELD_W-1:0] rel_angle,
  input logic signed [FIELD_W-1:0] raw_angle,
  input logic signed [TURNS_W-1:0] turn_count
);

  // Drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rel_angle) && $stable(turn_count))
    else $error("stalled result changed");

  // One wrap of a difference of two decoded angles stays within +-29535
  a_rel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rel_angle >= -17'sd29535 && rel_angle <= 17'sd29535)
    else $error("relative angle outside single wrap range");

  a_raw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> raw_angle >= -17'sd32767 && raw_angle <= 17'sd32768)
    else $error("decoded angle outside field range");

endmodule

bind gyro_frame_parser_angle_tracker_unit gfpat_checker u_gfpat_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .rel_angle  (rel_angle),
  .raw_angle  (raw_angle),
  .turn_count (turn_count)
);
